FILE: design/nhbt_pkg.sv
// Package: shared types and constants for the name hash bucket table.
package nhbt_pkg;
  localparam int unsigned HashBase  = 100000;
  localparam int unsigned UpperLow  = 64;
  localparam int unsigned UpperHigh = 91;
  localparam int unsigned CaseStep  = 32;
  localparam int unsigned PrefixBytes = 8;
  localparam int unsigned MaxKeyBytes = 32;
  localparam int unsigned SumBits   = 24;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_LISTED   = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  localparam logic KIND_INSERT = 1'b0;

  typedef logic [7:0] byte_t;

  function automatic byte_t fold_byte(input byte_t c);
    if (c > byte_t'(UpperLow) && c < byte_t'(UpperHigh)) begin
      return c + byte_t'(CaseStep);
    end
    return c;
  endfunction
endpackage

FILE: design/nhbt_hash_lane.sv
// Hash lane: folds one 8-byte key word, weights it by position, sums the word.
module nhbt_hash_lane import nhbt_pkg::*; #(
  parameter int unsigned LANE = 0
) (
  input  logic [63:0]  word,
  input  logic [5:0]   key_len,
  output logic [63:0]  folded,
  output logic [nhbt_pkg::SumBits-1:0] partial
);
  always_comb begin
    byte_t c;
    logic [5:0] pos;
    partial = '0;
    folded  = '0;
    for (int j = 0; j < 8; j++) begin
      pos = 6'(LANE * 8 + j);
      c = fold_byte(word[j*8 +: 8]);
      if (pos >= key_len) begin
        c = '0;
      end
      folded[j*8 +: 8] = c;
      partial = partial + SumBits'(c) * SumBits'(pos + 6'd1);
    end
  end
endmodule

FILE: design/name_hash_bucket_table_unit.sv
// Top level: hashed bucket table with insert/update and bucket listing.
//  channel | ports                                   | handshake
//  in      | in_kind, in_key_bytes_*, in_key_length, | start & !busy
//          | in_record_value                         |
//  out     | out_status .. out_last                  | out_valid, one cycle
// Four hash lanes fold and weight one key word each; their sums are registered, then merged.
// Insert: busy through hash, read and a scan of every entry on a miss or full bucket (one entry compare per cycle);
// a match at entry i ends the scan there.
// Lookup: one result per entry after the first memory read; an empty bucket gives one ST_EMPTY result.
// Reset clears the fill counters one bucket at a time; busy stays high meanwhile.
// The receiver cannot stall; each result is shown for one cycle.
module name_hash_bucket_table_unit import nhbt_pkg::*; #(
  parameter int unsigned NUM_BUCKETS = 1024,
  parameter int unsigned BUCKET_WAYS = 8,
  parameter int unsigned KEY_BYTES   = 32,
  parameter int unsigned VALUE_BITS  = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [63:0] in_key_bytes_lo,
  input  logic [63:0] in_key_bytes_mid_lo,
  input  logic [63:0] in_key_bytes_mid_hi,
  input  logic [63:0] in_key_bytes_hi,
  input  logic [5:0]  in_key_length,
  input  logic [VALUE_BITS-1:0] in_record_value,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [9:0]  out_bucket_index,
  output logic [3:0]  out_entry_count,
  output logic [VALUE_BITS-1:0] out_found_value,
  output logic        out_last
);
  localparam int unsigned BB = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned WB = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
  localparam int unsigned FB = $clog2(BUCKET_WAYS + 1);
  localparam int unsigned EB = BB + WB;
  localparam int unsigned NE = NUM_BUCKETS * BUCKET_WAYS;
  localparam int unsigned SB = SumBits + 2;

  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_HASH = 3'd2, S_READ = 3'd3,
                         S_SCAN = 3'd4, S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [BB-1:0] clr_r;

  logic [63:0] words [4];
  logic [63:0] folded [4];
  logic [SumBits-1:0] part [4];
  logic [5:0] len_c;

  assign words[0] = in_key_bytes_lo;
  assign words[1] = in_key_bytes_mid_lo;
  assign words[2] = in_key_bytes_mid_hi;
  assign words[3] = in_key_bytes_hi;
  assign len_c = (in_key_length > 6'(KEY_BYTES)) ? 6'(KEY_BYTES) : in_key_length;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    nhbt_hash_lane #(.LANE(g)) u_lane (
      .word(words[g]), .key_len(len_c), .folded(folded[g]), .partial(part[g]));
  end

  logic [SumBits-1:0] part_r [4];
  logic [63:0] prefix_r;
  logic kind_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [BB-1:0] bkt_r;
  logic [FB-1:0] fill_r;
  logic [WB:0] idx_r;
  logic [FB-1:0] fill_mem [NUM_BUCKETS];
  logic [63:0] key_mem [NE];
  logic [VALUE_BITS-1:0] val_mem [NE];
  logic [63:0] rd_key_r;
  logic [VALUE_BITS-1:0] rd_val_r;
  logic [FB-1:0] fill_rd_r;

  logic [SB-1:0] sum_c;
  logic [BB-1:0] bkt_c;
  assign sum_c = SB'(part_r[0]) + SB'(part_r[1]) + SB'(part_r[2]) + SB'(part_r[3])
                 + SB'(HashBase);
  assign bkt_c = BB'(sum_c % SB'(NUM_BUCKETS));

  logic [EB-1:0] rd_addr;
  logic [WB-1:0] idx_w;
  assign idx_w = WB'(idx_r);
  assign rd_addr = {bkt_r, idx_w};

  assign busy = (state_r != S_IDLE);

  logic out_valid_r, out_last_r;
  logic [2:0] out_status_r;
  logic [3:0] out_count_r;
  logic [VALUE_BITS-1:0] out_val_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (clr_r == BB'(NUM_BUCKETS - 1)) state_nxt = S_IDLE;
      S_IDLE: if (start) state_nxt = S_HASH;
      S_HASH: state_nxt = S_READ;
      S_READ: state_nxt = S_SCAN;
      S_SCAN: if ((WB + 1)'(fill_r) == idx_r ||
                  (kind_r == KIND_INSERT && rd_key_r == prefix_r)) state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          fill_mem[clr_r] <= '0;
          clr_r <= clr_r + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            for (int k = 0; k < 4; k++) part_r[k] <= part[k];
            prefix_r <= folded[0];
            kind_r <= in_kind;
            val_r <= in_record_value;
          end
        end
        S_HASH: begin
          bkt_r <= bkt_c;
          fill_rd_r <= fill_mem[bkt_c];
        end
        S_READ: begin
          fill_r <= fill_rd_r;
          idx_r <= '0;
          rd_key_r <= key_mem[{bkt_r, WB'(0)}];
          rd_val_r <= val_mem[{bkt_r, WB'(0)}];
        end
        S_SCAN: begin
          if ((WB + 1)'(fill_r) == idx_r) begin
            if (kind_r == KIND_INSERT) begin
              out_valid_r <= 1'b1;
              out_last_r <= 1'b1;
              out_val_r <= '0;
              if (fill_r >= FB'(BUCKET_WAYS)) begin
                out_status_r <= ST_FULL;
                out_count_r <= 4'(fill_r);
              end else begin
                key_mem[rd_addr] <= prefix_r;
                val_mem[rd_addr] <= val_r;
                fill_mem[bkt_r] <= fill_r + 1'b1;
                out_status_r <= ST_INSERTED;
                out_count_r <= 4'(fill_r + 1'b1);
              end
            end else if (fill_r == '0) begin
              out_valid_r <= 1'b1;
              out_last_r <= 1'b1;
              out_val_r <= '0;
              out_status_r <= ST_EMPTY;
              out_count_r <= '0;
            end
          end else begin
            idx_r <= idx_r + 1'b1;
            rd_key_r <= key_mem[{bkt_r, WB'(idx_r + 1'b1)}];
            rd_val_r <= val_mem[{bkt_r, WB'(idx_r + 1'b1)}];
            if (kind_r == KIND_INSERT) begin
              if (rd_key_r == prefix_r) begin
                val_mem[rd_addr] <= val_r;
                out_valid_r <= 1'b1;
                out_last_r <= 1'b1;
                out_val_r <= '0;
                out_status_r <= ST_UPDATED;
                out_count_r <= 4'(fill_r);
              end
            end else begin
              out_valid_r <= 1'b1;
              out_last_r <= ((WB + 1)'(fill_r) == idx_r + 1'b1);
              out_val_r <= rd_val_r;
              out_status_r <= ST_LISTED;
              out_count_r <= 4'(fill_r);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_bucket_index = 10'(bkt_r);
  assign out_entry_count = out_count_r;
  assign out_found_value = out_val_r;
  assign out_last = out_last_r;
endmodule
